### hdl/pip_pkg.sv
package pip_pkg;

  localparam int MaxVertices = 64;
  localparam int IdxW = $clog2(MaxVertices);
  localparam int CntW = $clog2(MaxVertices + 1);
  localparam int CoordW = 16;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_QUERY  = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  typedef struct packed {
    logic [1:0]               cmd;
    logic signed [CoordW-1:0] coord_x;
    logic signed [CoordW-1:0] coord_y;
  } req_t;

  typedef struct packed {
    logic inside_res;
    logic degenerate;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH_FIRST,
    ST_WALK,
    ST_DONE,
    ST_OUT
  } state_e;

  // Controller to datapath.
  typedef struct packed {
    logic                 load_req;
    logic                 do_clear;
    logic                 do_append;
    logic                 rd_en;
    logic [IdxW-1:0]      rd_addr;
    logic                 first_beat;
    logic                 edge_en;
    logic                 close_edge;
    logic                 degen_rsp;
  } ctl_t;

  // Datapath to controller.
  typedef struct packed {
    logic [CntW-1:0] count;
    logic            decided;
  } sts_t;

  // Sign of a product difference as orientation code: 0 collinear, 1 cw, 2 ccw.
  function automatic logic [1:0] orient_code(input logic signed [35:0] v);
    logic [1:0] r;
    if (v == '0) r = 2'd0;
    else if (v > 0) r = 2'd1;
    else r = 2'd2;
    return r;
  endfunction

endpackage

### hdl/point_in_polygon_test.sv
// Point-in-polygon tester by ray casting over a stored polygon.
// One request channel (in_valid_i, in_stall_o, in_req_i) carries a command
// with a point: clear the polygon, append a vertex, or query the point.
// Clear and append give no response. A query gives one
// response on the response channel (out_valid_o, out_stall_i, out_rsp_o).
// A query walks the stored edges one per cycle, reading vertices from a
// registered RAM. A polygon under three vertices answers with the
// degenerate flag. A point on an edge ends the walk early.
// The block holds one request at a time: in_stall_o stays high from a
// query until its response is taken, and the response stays stable while
// out_stall_i is high. Reset empties the polygon and sets the largest x
// to minus one; the vertex RAM is not cleared, since only written entries
// are read.
module point_in_polygon_test (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  pip_pkg::req_t in_req_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output pip_pkg::rsp_t out_rsp_o
);
  import pip_pkg::*;

  ctl_t ctl;
  sts_t sts;

  pip_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .cmd_i(in_req_i.cmd),
    .out_valid_o, .out_stall_i, .sts_i(sts), .ctl_o(ctl)
  );

  pip_dp u_dp (
    .clk_i, .rst_ni, .req_i(in_req_i), .ctl_i(ctl), .sts_o(sts), .rsp_o(out_rsp_o)
  );

  // A degenerate response never claims inside.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.degenerate |-> !out_rsp_o.inside_res)
    else $error("degenerate response marked inside");

  // The vertex count never exceeds capacity.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts.count <= CntW'(MaxVertices))
    else $error("vertex count beyond capacity");

  // A response held under stall keeps its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("response changed under stall");

endmodule

### hdl/pip_ram.sv
module pip_ram #(
  parameter int Width = 16,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    if (re_i) rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/pip_ctrl.sv
module pip_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic [1:0]    cmd_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  input  pip_pkg::sts_t sts_i,
  output pip_pkg::ctl_t ctl_o
);
  import pip_pkg::*;

  state_e          state_q, state_d;
  logic [CntW-1:0] idx_q, idx_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    ctl_o       = '0;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          case (cmd_e'(cmd_i))
            CMD_CLEAR:  ctl_o.do_clear = 1'b1;
            CMD_APPEND: ctl_o.do_append = 1'b1;
            CMD_QUERY: begin
              ctl_o.load_req = 1'b1;
              if (sts_i.count < CntW'(3)) begin
                ctl_o.degen_rsp = 1'b1;
                state_d = ST_OUT;
              end else begin
                ctl_o.rd_en = 1'b1;
                ctl_o.rd_addr = '0;
                idx_d = '0;
                state_d = ST_FETCH_FIRST;
              end
            end
            default: ;
          endcase
        end
      end
      ST_FETCH_FIRST: begin
        // Vertex 0 is on the read port now; keep it and fetch vertex 1.
        ctl_o.first_beat = 1'b1;
        ctl_o.rd_en = 1'b1;
        ctl_o.rd_addr = IdxW'(1);
        idx_d = CntW'(1);
        state_d = ST_WALK;
      end
      ST_WALK: begin
        // Index equal to the count means the closing edge back to vertex 0.
        ctl_o.edge_en = 1'b1;
        ctl_o.close_edge = (idx_q == sts_i.count);
        if ((idx_q == sts_i.count) || sts_i.decided) begin
          state_d = ST_DONE;
        end else begin
          ctl_o.rd_en = 1'b1;
          ctl_o.rd_addr = IdxW'(idx_q + CntW'(1));
          idx_d = idx_q + CntW'(1);
        end
      end
      ST_DONE: state_d = ST_OUT;
      ST_OUT: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

### hdl/pip_dp.sv
module pip_dp (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  pip_pkg::req_t req_i,
  input  pip_pkg::ctl_t ctl_i,
  output pip_pkg::sts_t sts_o,
  output pip_pkg::rsp_t rsp_o
);
  import pip_pkg::*;

  logic [CntW-1:0]          count_q;
  logic signed [CoordW-1:0] max_x_q;
  logic signed [CoordW-1:0] px_q, py_q;
  logic signed [CoordW-1:0] ax_q, ay_q, fx_q, fy_q;
  logic signed [CoordW:0]   ex_q;
  logic                     decided_q, ans_q, par_q, degen_q;
  logic signed [CoordW-1:0] rd_x, rd_y, bx, by;
  logic                     wr;

  assign wr = ctl_i.do_append && (count_q < CntW'(MaxVertices));

  pip_ram #(.Width(CoordW), .Depth(MaxVertices)) u_ram_x (
    .clk_i, .we_i(wr), .waddr_i(count_q[IdxW-1:0]), .wdata_i(req_i.coord_x),
    .re_i(ctl_i.rd_en), .raddr_i(ctl_i.rd_addr), .rdata_o(rd_x)
  );
  pip_ram #(.Width(CoordW), .Depth(MaxVertices)) u_ram_y (
    .clk_i, .we_i(wr), .waddr_i(count_q[IdxW-1:0]), .wdata_i(req_i.coord_y),
    .re_i(ctl_i.rd_en), .raddr_i(ctl_i.rd_addr), .rdata_o(rd_y)
  );

  // The closing edge returns to vertex 0.
  assign bx = ctl_i.close_edge ? fx_q : rd_x;
  assign by = ctl_i.close_edge ? fy_q : rd_y;

  // Edge a-b against segment p-e (horizontal, e.y = p.y), 18-bit signed math.
  logic signed [17:0] axw, ayw, bxw, byw, pxw, pyw, exw;
  logic [1:0] o1, o2, o3, o4;
  logic in1, in2, in3, in4, meet, on_edge;

  always_comb begin
    axw = 18'(ax_q); ayw = 18'(ay_q); bxw = 18'(bx); byw = 18'(by);
    pxw = 18'(px_q); pyw = 18'(py_q); exw = 18'(ex_q);
    o1 = orient_code(36'((byw - ayw) * (pxw - bxw)) - 36'((bxw - axw) * (pyw - byw)));
    o2 = orient_code(36'((byw - ayw) * (exw - bxw)) - 36'((bxw - axw) * (pyw - byw)));
    o3 = orient_code(36'(-((exw - pxw) * (ayw - pyw))));
    o4 = orient_code(36'(-((exw - pxw) * (byw - pyw))));
    in1 = (pxw <= ((axw > bxw) ? axw : bxw)) && (pxw >= ((axw < bxw) ? axw : bxw)) &&
          (pyw <= ((ayw > byw) ? ayw : byw)) && (pyw >= ((ayw < byw) ? ayw : byw));
    in2 = (exw <= ((axw > bxw) ? axw : bxw)) && (exw >= ((axw < bxw) ? axw : bxw)) &&
          (pyw <= ((ayw > byw) ? ayw : byw)) && (pyw >= ((ayw < byw) ? ayw : byw));
    // The query point may lie beyond the segment end, so both orders are allowed.
    in3 = (axw <= ((pxw > exw) ? pxw : exw)) && (axw >= ((pxw < exw) ? pxw : exw)) &&
          (ayw == pyw);
    in4 = (bxw <= ((pxw > exw) ? pxw : exw)) && (bxw >= ((pxw < exw) ? pxw : exw)) &&
          (byw == pyw);
    meet = ((o1 != o2) && (o3 != o4)) || (o1 == 2'd0 && in1) || (o2 == 2'd0 && in2) ||
           (o3 == 2'd0 && in3) || (o4 == 2'd0 && in4);
    // orient(a, p, b) is zero exactly when o1 is zero.
    on_edge = (o1 == 2'd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      max_x_q   <= '1;
      decided_q <= 1'b0;
      degen_q   <= 1'b0;
      ans_q     <= 1'b0;
      par_q     <= 1'b0;
    end else begin
      if (ctl_i.do_clear) begin
        count_q <= '0;
        max_x_q <= '1;
      end else if (wr) begin
        count_q <= count_q + CntW'(1);
        if (req_i.coord_x > max_x_q) max_x_q <= req_i.coord_x;
      end
      if (ctl_i.load_req) begin
        decided_q <= 1'b0;
        par_q     <= 1'b0;
        ans_q     <= 1'b0;
        degen_q   <= ctl_i.degen_rsp;
      end else if (ctl_i.edge_en && !decided_q && meet) begin
        if (on_edge) begin
          decided_q <= 1'b1;
          ans_q     <= in1;
        end else begin
          par_q <= ~par_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load_req) begin
      px_q <= req_i.coord_x;
      py_q <= req_i.coord_y;
      ex_q <= 17'(max_x_q) + 17'sd1;
    end
    if (ctl_i.first_beat) begin
      ax_q <= rd_x; ay_q <= rd_y; fx_q <= rd_x; fy_q <= rd_y;
    end else if (ctl_i.edge_en) begin
      ax_q <= rd_x; ay_q <= rd_y;
    end
  end

  assign sts_o.count   = count_q;
  assign sts_o.decided = decided_q;
  assign rsp_o.inside_res = !degen_q && (decided_q ? ans_q : par_q);
  assign rsp_o.degenerate = degen_q;

endmodule
